@@ rtl/hpn_pkg.sv @@
// Package: shared widths, register indexes, command struct and arctangent table.
package hpn_pkg;

	localparam int POS_W      = 16;
	localparam int YAW_W      = 15;
	localparam int RATE_W     = 32;
	localparam int ERR_W      = 16;
	localparam int GAIN_W     = 16;
	localparam int RAD_W      = 15;
	localparam int CFG_IDX_W  = 4;
	localparam int CFG_DATA_W = 16;
	localparam int ITER_W     = 4;   // arctangent table has 16 entries

	localparam int DIFF_W = POS_W + 1;   // goal minus robot
	localparam int CRD_W  = 27;          // CORDIC x/y, Q.8 differences with growth
	localparam int ANG_W  = 20;          // CORDIC angle, Q.16 radians
	localparam int E_W    = 18;          // heading error before wrap
	localparam int MA_W   = 33;          // multiplier operand a
	localparam int MB_W   = 17;          // multiplier operand b
	localparam int PROD_W = MA_W + MB_W;
	localparam int ACC_W  = PROD_W;

	localparam logic signed [ANG_W-1:0] PI_Q16     = ANG_W'(205887);
	localparam logic signed [E_W-1:0]   PI_Q12     = E_W'(12868);
	localparam logic signed [E_W-1:0]   TWO_PI_Q12 = E_W'(25736);

	localparam logic [CFG_IDX_W-1:0] REG_GAIN_PROP  = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_GAIN_INTEG = CFG_IDX_W'(1);
	localparam logic [CFG_IDX_W-1:0] REG_GAIN_DERIV = CFG_IDX_W'(2);
	localparam logic [CFG_IDX_W-1:0] REG_ARR_RADIUS = CFG_IDX_W'(3);

	typedef enum logic [2:0] {
		MS_DXX,
		MS_DYY,
		MS_RAD,
		MS_PROP,
		MS_INTEG,
		MS_DERIV
	} mul_sel_t;

	typedef enum logic [1:0] {
		ACC_HOLD,
		ACC_LOAD,
		ACC_ADD
	} acc_op_t;

	typedef struct packed {
		logic              load;
		mul_sel_t          mul_sel;
		acc_op_t           acc_op;
		logic              cmp_arrive;
		logic              cordic_step;
		logic [ITER_W-1:0] iter;
		logic              err_calc;
		logic              pid_update;
		logic              out_load;
	} hpn_cmd_t;

	// atan(2^-i) in Q.16 radians
	function automatic logic signed [ANG_W-1:0] atan_q16(input logic [ITER_W-1:0] i);
		logic signed [ANG_W-1:0] r;
		case (i)
			4'd0:    r = ANG_W'(51472);
			4'd1:    r = ANG_W'(30386);
			4'd2:    r = ANG_W'(16055);
			4'd3:    r = ANG_W'(8150);
			4'd4:    r = ANG_W'(4091);
			4'd5:    r = ANG_W'(2047);
			4'd6:    r = ANG_W'(1024);
			4'd7:    r = ANG_W'(512);
			4'd8:    r = ANG_W'(256);
			4'd9:    r = ANG_W'(128);
			4'd10:   r = ANG_W'(64);
			4'd11:   r = ANG_W'(32);
			4'd12:   r = ANG_W'(16);
			4'd13:   r = ANG_W'(8);
			4'd14:   r = ANG_W'(4);
			4'd15:   r = ANG_W'(2);
			default: r = '0;
		endcase
		return r;
	endfunction

endpackage

@@ rtl/hpn_pose_if.sv @@
// Interface: pose channel (robot and goal pose words).
interface hpn_pose_if import hpn_pkg::*; ();
	logic                    valid;
	logic                    ready;
	logic signed [POS_W-1:0] robot_x;
	logic signed [POS_W-1:0] robot_y;
	logic signed [YAW_W-1:0] robot_yaw;
	logic signed [POS_W-1:0] goal_x;
	logic signed [POS_W-1:0] goal_y;
	logic signed [YAW_W-1:0] goal_yaw;

	modport source (output valid, robot_x, robot_y, robot_yaw, goal_x, goal_y, goal_yaw,
		input ready);
	modport sink (input valid, robot_x, robot_y, robot_yaw, goal_x, goal_y, goal_yaw,
		output ready);
endinterface

@@ rtl/hpn_result_if.sv @@
// Interface: result channel (turn command words).
interface hpn_result_if import hpn_pkg::*; ();
	logic                     valid;
	logic                     ready;
	logic signed [RATE_W-1:0] turn_rate;
	logic signed [ERR_W-1:0]  heading_error;
	logic                     arrived;

	modport source (output valid, turn_rate, heading_error, arrived, input ready);
	modport sink (input valid, turn_rate, heading_error, arrived, output ready);
endinterface

@@ rtl/hpn_cfg_if.sv @@
// Interface: configuration write channel.
interface hpn_cfg_if import hpn_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

@@ rtl/hpn_datapath.sv @@
// Datapath: config registers, CORDIC unit, shared multiplier, accumulator, PID state.
module hpn_datapath import hpn_pkg::*; (
	input  logic                         clk,
	input  logic                         arst_n,
	input  hpn_cmd_t                     cmd,
	input  logic                         cfg_we,
	input  logic [CFG_IDX_W-1:0]         cfg_index,
	input  logic [CFG_DATA_W-1:0]        cfg_data,
	input  logic signed [POS_W-1:0]      robot_x,
	input  logic signed [POS_W-1:0]      robot_y,
	input  logic signed [YAW_W-1:0]      robot_yaw,
	input  logic signed [POS_W-1:0]      goal_x,
	input  logic signed [POS_W-1:0]      goal_y,
	input  logic signed [YAW_W-1:0]      goal_yaw,
	output logic signed [RATE_W-1:0]     turn_rate,
	output logic signed [ERR_W-1:0]      heading_error,
	output logic                         arrived
);

	localparam logic signed [33:0] S32_MAX = 34'sh0_7FFF_FFFF;
	localparam logic signed [33:0] S32_MIN = -34'sh0_8000_0000;
	localparam int SH_W = ACC_W + 1 - 8;

	// configuration
	logic [GAIN_W-1:0] gain_prop_q, gain_integ_q, gain_deriv_q;
	logic [RAD_W-1:0]  radius_q;

	// item operands
	logic signed [DIFF_W-1:0] dx_q, dy_q;
	logic signed [YAW_W-1:0]  ryaw_q, gyaw_q;
	logic                     zero_q;
	logic                     arrived_q;

	// CORDIC
	logic signed [CRD_W-1:0]  x_q, y_q;
	logic signed [ANG_W-1:0]  z_q;

	// PID
	logic signed [ERR_W-1:0]  e_q, prev_q;
	logic signed [ERR_W:0]    diff_q;
	logic signed [31:0]       integral_q;

	// multiplier / accumulator
	logic signed [MA_W-1:0]   mul_a;
	logic signed [MB_W-1:0]   mul_b;
	logic signed [PROD_W-1:0] prod_q;
	logic signed [ACC_W-1:0]  acc_q;

	// outputs
	logic signed [RATE_W-1:0] rate_q;
	logic signed [ERR_W-1:0]  err_out_q;
	logic                     arr_out_q;

	// load-time pre-rotation into the right half plane
	logic signed [DIFF_W-1:0] ld_dx, ld_dy;
	logic signed [CRD_W-1:0]  ld_x, ld_y;

	always_comb begin
		ld_dx = DIFF_W'(goal_x) - DIFF_W'(robot_x);
		ld_dy = DIFF_W'(goal_y) - DIFF_W'(robot_y);
		ld_x  = CRD_W'(ld_dx) <<< 8;
		ld_y  = CRD_W'(ld_dy) <<< 8;
	end

	// CORDIC step
	logic signed [CRD_W-1:0] xs, ys;
	logic signed [ANG_W-1:0] at;

	always_comb begin
		xs = x_q >>> cmd.iter;
		ys = y_q >>> cmd.iter;
		at = atan_q16(cmd.iter);
	end

	// heading error and wrap
	logic signed [ANG_W:0]  z_rnd;
	logic signed [E_W-1:0]  bearing, e_raw, e_wrap;

	always_comb begin
		z_rnd   = (ANG_W+1)'(z_q) + (ANG_W+1)'(8);
		bearing = zero_q ? '0 : E_W'(z_rnd >>> 4);
		e_raw   = (arrived_q ? E_W'(gyaw_q) : bearing) - E_W'(ryaw_q);
		if (e_raw > PI_Q12) begin
			e_wrap = e_raw - TWO_PI_Q12;
		end else if (e_raw < -PI_Q12) begin
			e_wrap = e_raw + TWO_PI_Q12;
		end else begin
			e_wrap = e_raw;
		end
	end

	// integral update
	logic signed [33:0] isum, isat;

	always_comb begin
		isum = 34'(integral_q) + 34'(e_q);
		if (isum > S32_MAX) begin
			isat = S32_MAX;
		end else if (isum < S32_MIN) begin
			isat = S32_MIN;
		end else begin
			isat = isum;
		end
	end

	// operand select for the shared multiplier
	always_comb begin
		case (cmd.mul_sel)
			MS_DXX: begin
				mul_a = MA_W'(dx_q);
				mul_b = MB_W'(dx_q);
			end
			MS_DYY: begin
				mul_a = MA_W'(dy_q);
				mul_b = MB_W'(dy_q);
			end
			MS_RAD: begin
				mul_a = MA_W'({1'b0, radius_q});
				mul_b = MB_W'({1'b0, radius_q});
			end
			MS_PROP: begin
				mul_a = MA_W'(e_q);
				mul_b = MB_W'({1'b0, gain_prop_q});
			end
			MS_INTEG: begin
				mul_a = MA_W'(integral_q);
				mul_b = MB_W'({1'b0, gain_integ_q});
			end
			MS_DERIV: begin
				mul_a = MA_W'(diff_q);
				mul_b = MB_W'({1'b0, gain_deriv_q});
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	// round and saturate the PID sum
	logic signed [ACC_W:0]  acc_rnd;
	logic signed [SH_W-1:0] acc_sh;
	logic signed [RATE_W-1:0] rate_sat;

	always_comb begin
		acc_rnd = (ACC_W+1)'(acc_q) + (ACC_W+1)'(128);
		acc_sh  = SH_W'(acc_rnd >>> 8);
		if (acc_sh > SH_W'(S32_MAX)) begin
			rate_sat = RATE_W'(S32_MAX);
		end else if (acc_sh < SH_W'(S32_MIN)) begin
			rate_sat = RATE_W'(S32_MIN);
		end else begin
			rate_sat = RATE_W'(acc_sh);
		end
	end

	// config and PID state: reset values matter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_prop_q  <= GAIN_W'(1459);
			gain_integ_q <= GAIN_W'(913);
			gain_deriv_q <= GAIN_W'(228);
			radius_q     <= RAD_W'(13);
			integral_q   <= '0;
			prev_q       <= '0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_GAIN_PROP:  gain_prop_q  <= cfg_data[GAIN_W-1:0];
					REG_GAIN_INTEG: gain_integ_q <= cfg_data[GAIN_W-1:0];
					REG_GAIN_DERIV: gain_deriv_q <= cfg_data[GAIN_W-1:0];
					REG_ARR_RADIUS: radius_q     <= cfg_data[RAD_W-1:0];
					default: ;
				endcase
			end
			if (cmd.pid_update) begin
				integral_q <= 32'(isat);
				prev_q     <= e_q;
			end
		end
	end

	// working registers
	always_ff @(posedge clk) begin
		prod_q <= mul_a * mul_b;

		case (cmd.acc_op)
			ACC_LOAD: acc_q <= prod_q;
			ACC_ADD:  acc_q <= acc_q + prod_q;
			default:  ;
		endcase

		if (cmd.load) begin
			dx_q   <= ld_dx;
			dy_q   <= ld_dy;
			ryaw_q <= robot_yaw;
			gyaw_q <= goal_yaw;
			zero_q <= (ld_dx == '0) && (ld_dy == '0);
			if (ld_dx < 0) begin
				x_q <= -ld_x;
				y_q <= -ld_y;
				z_q <= (ld_dy >= 0) ? PI_Q16 : -PI_Q16;
			end else begin
				x_q <= ld_x;
				y_q <= ld_y;
				z_q <= '0;
			end
		end else if (cmd.cordic_step) begin
			if (y_q >= 0) begin
				x_q <= x_q + ys;
				y_q <= y_q - xs;
				z_q <= z_q + at;
			end else begin
				x_q <= x_q - ys;
				y_q <= y_q + xs;
				z_q <= z_q - at;
			end
		end

		if (cmd.cmp_arrive) begin
			arrived_q <= acc_q < prod_q;
		end

		if (cmd.err_calc) begin
			e_q <= ERR_W'(e_wrap);
		end

		if (cmd.pid_update) begin
			diff_q <= (ERR_W+1)'(e_q) - (ERR_W+1)'(prev_q);
		end

		if (cmd.out_load) begin
			rate_q    <= rate_sat;
			err_out_q <= e_q;
			arr_out_q <= arrived_q;
		end
	end

	assign turn_rate     = rate_q;
	assign heading_error = err_out_q;
	assign arrived       = arr_out_q;

endmodule

@@ rtl/hpn_ctrl.sv @@
// Controller: sequences distance test, CORDIC iterations and PID multiply-accumulate.
module hpn_ctrl import hpn_pkg::*; #(
	parameter int CORDIC_STEPS = 14
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	output logic     out_valid,
	input  logic     out_ready,
	output hpn_cmd_t cmd
);

	localparam int CW = (CORDIC_STEPS > 1) ? $clog2(CORDIC_STEPS) : 1;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SQX,
		ST_SQY,
		ST_RAD,
		ST_CMP,
		ST_CORD,
		ST_ERR,
		ST_INTEG,
		ST_M_I,
		ST_M_D,
		ST_M_END,
		ST_FIN
	} state_t;

	state_t          state_q;
	logic [CW-1:0]   cnt_q;
	logic            out_valid_q;
	logic            fin_go;

	assign fin_go    = (state_q == ST_FIN) && (!out_valid_q || out_ready);
	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		cmd             = '0;
		cmd.mul_sel     = MS_DXX;
		cmd.acc_op      = ACC_HOLD;
		cmd.iter        = ITER_W'(cnt_q);
		case (state_q)
			ST_IDLE:  cmd.load = in_valid;
			ST_SQX:   cmd.mul_sel = MS_DXX;
			ST_SQY: begin
				cmd.mul_sel = MS_DYY;
				cmd.acc_op  = ACC_LOAD;
			end
			ST_RAD: begin
				cmd.mul_sel = MS_RAD;
				cmd.acc_op  = ACC_ADD;
			end
			ST_CMP:   cmd.cmp_arrive = 1'b1;
			ST_CORD:  cmd.cordic_step = 1'b1;
			ST_ERR:   cmd.err_calc = 1'b1;
			ST_INTEG: begin
				cmd.pid_update = 1'b1;
				cmd.mul_sel    = MS_PROP;
			end
			ST_M_I: begin
				cmd.mul_sel = MS_INTEG;
				cmd.acc_op  = ACC_LOAD;
			end
			ST_M_D: begin
				cmd.mul_sel = MS_DERIV;
				cmd.acc_op  = ACC_ADD;
			end
			ST_M_END: cmd.acc_op = ACC_ADD;
			ST_FIN:   cmd.out_load = fin_go;
			default:  ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (fin_go) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end

			case (state_q)
				ST_IDLE: if (in_valid) begin
					state_q <= ST_SQX;
				end
				ST_SQX: state_q <= ST_SQY;
				ST_SQY: state_q <= ST_RAD;
				ST_RAD: state_q <= ST_CMP;
				ST_CMP: begin
					cnt_q   <= '0;
					state_q <= ST_CORD;
				end
				ST_CORD: begin
					if (cnt_q == CW'(CORDIC_STEPS - 1)) begin
						state_q <= ST_ERR;
					end
					cnt_q <= cnt_q + 1'b1;
				end
				ST_ERR:   state_q <= ST_INTEG;
				ST_INTEG: state_q <= ST_M_I;
				ST_M_I:   state_q <= ST_M_D;
				ST_M_D:   state_q <= ST_M_END;
				ST_M_END: state_q <= ST_FIN;
				ST_FIN: if (fin_go) begin
					state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

@@ rtl/heading_pid_navigator.sv @@
// Top level: heading PID controller with CORDIC bearing, controller and datapath.
//
// Usage notes
//  - pose:   one word per control tick (robot x/y/yaw, goal x/y/yaw), valid/ready.
//  - result: one word per pose word (turn_rate, heading_error, arrived), valid/ready.
//  - cfg:    register writes (0 gain_prop, 1 gain_integ, 2 gain_deriv,
//            3 arrival_radius); always ready, unknown indexes ignored.
//            Write only while the block is idle.
//  - Sequence: once a pose word is accepted, the block squares dx, dy and the
//    radius, tests for arrival, runs the CORDIC micro-rotations, forms the
//    heading error, updates the PID state, sums the three PID products and
//    loads the result register. One item at a time: a new pose word is
//    taken only after the last one is loaded for output. The CORDIC unit does one
//    micro-rotation per cycle; the shared multiplier is used six times per item.
//  - Reset (arst_n low): gains and radius return to their defaults, the
//    integral and previous error clear, no result is pending.
//  - Stall: a finished word sits in the output register. The next pose word
//    may be taken and worked on meanwhile; it waits in its last step if the
//    earlier word is still not taken.
//
module heading_pid_navigator import hpn_pkg::*; #(
	parameter int CORDIC_STEPS = 14
) (
	input  logic          clk,
	input  logic          arst_n,
	hpn_pose_if.sink      pose,
	hpn_result_if.source  result,
	hpn_cfg_if.sink       cfg
);

	hpn_cmd_t cmd;

	// configuration never back-pressures
	assign cfg.ready = 1'b1;

	hpn_ctrl #(
		.CORDIC_STEPS(CORDIC_STEPS)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (pose.valid),
		.in_ready  (pose.ready),
		.out_valid (result.valid),
		.out_ready (result.ready),
		.cmd       (cmd)
	);

	hpn_datapath u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.cfg_we        (cfg.valid),
		.cfg_index     (cfg.index),
		.cfg_data      (cfg.data),
		.robot_x       (pose.robot_x),
		.robot_y       (pose.robot_y),
		.robot_yaw     (pose.robot_yaw),
		.goal_x        (pose.goal_x),
		.goal_y        (pose.goal_y),
		.goal_yaw      (pose.goal_yaw),
		.turn_rate     (result.turn_rate),
		.heading_error (result.heading_error),
		.arrived       (result.arrived)
	);

endmodule
